FILE: src/trigger_aligned_event_builder_assert.svh
// assertion macros shared by the event builder modules
// no dependencies; included by each module that carries assertions
`ifndef TRIGGER_ALIGNED_EVENT_BUILDER_ASSERT_SVH
`define TRIGGER_ALIGNED_EVENT_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define TEAB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TEAB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TEAB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TEAB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/teab_pkg.sv
// shared types and constants of the trigger aligned event builder
// no dependencies
package teab_pkg;

    localparam int CHAN_W = 3;
    localparam int TRIG_W = 32;
    localparam int DATA_W = 32;
    localparam int MAX_CH = 8;
    localparam int MASK_W = 8;
    localparam int SLOT_W = TRIG_W + DATA_W;

    typedef struct packed {
        logic [TRIG_W-1:0] trig;
        logic [DATA_W-1:0] data;
    } slot_t;

    // front to back: per channel status
    typedef struct packed {
        logic [MAX_CH-1:0] active;
        logic [MAX_CH-1:0] nonempty;
    } fe_status_t;

    // back to front: head of one channel fifo was consumed
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel;
    } pop_t;

    // queued build request, one per accepted item
    typedef struct packed {
        logic              appended;
        logic              dropped;
        logic [CHAN_W-1:0] channel;
    } check_t;

    typedef enum logic {
        F_IDLE,
        F_APPEND
    } fe_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_SCAN_WAIT,
        B_EMIT,
        B_EMIT_WAIT
    } be_state_t;

endpackage

FILE: src/teab_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module teab_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/teab_queue.sv
// two entry request queue between the front and the back
// depends on teab_pkg
module teab_queue import teab_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  check_t push_tok,
    input  logic   pop,
    output logic   tok_valid,
    output check_t tok
);

    check_t     entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    assign tok_valid = (count_reg != 2'd0);
    assign tok       = entry_reg[rd_ptr_reg];

endmodule

FILE: src/teab_front.sv
// front: takes items, classifies them, appends to the channel fifo
// depends on teab_pkg and the assertion macro header
`include "trigger_aligned_event_builder_assert.svh"
module teab_front import teab_pkg::*; #(
    parameter int CHANNELS = 8,
    parameter int QUEUE_DEPTH = 16,
    localparam int AW = $clog2(CHANNELS * QUEUE_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [CHAN_W-1:0] channel,
    input  logic [TRIG_W-1:0] trigger_number,
    input  logic [DATA_W-1:0] fragment_data,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_data,
    input  pop_t              pop,
    output fe_status_t        status,
    output logic              push,
    output check_t            push_tok,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output slot_t             wr_slot,
    output logic              front_busy,
    output logic              overflow
);

    localparam int CW = $clog2(CHANNELS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    fe_state_t         state_reg;
    fe_state_t         state_next;
    logic [CHAN_W-1:0] ch_reg;
    logic [TRIG_W-1:0] trig_reg;
    logic [DATA_W-1:0] data_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              ovf_reg;
    logic              ovf_next;
    logic [PW-1:0]     wptr_reg  [CHANNELS];
    logic [PW-1:0]     wptr_next [CHANNELS];
    logic [FW-1:0]     fill_reg  [CHANNELS];
    logic [FW-1:0]     fill_next [CHANNELS];
    logic [CW-1:0]     ci;
    logic [CW-1:0]     pc;
    logic              ch_active;
    logic              full;
    logic              do_append;
    logic              do_drop;
    logic [MAX_CH-1:0] act_vec;
    logic [MAX_CH-1:0] ne_vec;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_APPEND;
                end
            end
            F_APPEND:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        front_busy = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                front_busy = 1'b0;
            end
            F_APPEND:
            begin
                front_busy = 1'b1;
                push       = 1'b1;
            end
            default:
            begin
                front_busy = 1'b0;
            end
        endcase
    end

    assign ci        = ch_reg[CW-1:0];
    assign pc        = pop.channel[CW-1:0];
    assign ch_active = (32'(ch_reg) < CHANNELS) && mask_reg[ch_reg];
    assign full      = (fill_reg[ci] == FW'(QUEUE_DEPTH));
    assign do_append = (state_reg == F_APPEND) && ch_active && !full;
    assign do_drop   = (state_reg == F_APPEND) && ch_active && full;
    assign ovf_next  = ovf_reg | do_drop;

    assign push_tok = '{appended: do_append, dropped: do_drop, channel: ch_reg};

    assign wr_en   = do_append;
    assign wr_addr = AW'(int'(ci) * QUEUE_DEPTH + int'(wptr_reg[ci]));
    assign wr_slot = '{trig: trig_reg, data: data_reg};

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            wptr_next[i] = wptr_reg[i];
            fill_next[i] = fill_reg[i];
            if (do_append && (ci == CW'(i)))
            begin
                wptr_next[i] = (wptr_reg[i] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wptr_reg[i] + 1'b1;
                fill_next[i] = fill_reg[i] + 1'b1;
            end
            if (pop.valid && (pc == CW'(i)))
            begin
                fill_next[i] = fill_next[i] - 1'b1;
            end
        end
    end

    // channels at or above CHANNELS never take part
    for (genvar g = 0; g < MAX_CH; g++)
    begin : g_status
        if (g < CHANNELS)
        begin : g_on
            assign act_vec[g] = mask_reg[g];
            assign ne_vec[g]  = (fill_reg[g] != '0);
        end
        else
        begin : g_off
            assign act_vec[g] = 1'b0;
            assign ne_vec[g]  = 1'b0;
        end
    end

    assign status   = '{active: act_vec, nonempty: ne_vec};
    assign overflow = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            mask_reg  <= '0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                wptr_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_data;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                wptr_reg[i] <= wptr_next[i];
                fill_reg[i] <= fill_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= channel;
            trig_reg <= trigger_number;
            data_reg <= fragment_data;
        end
    end

    `TEAB_ASSERT_IMP(a_pop_not_on_append, clk, rst_n, pop.valid, state_reg != F_APPEND,
        "fifo pop during an append")
    `TEAB_ASSERT_NXT(a_accept_appends, clk, rst_n, accept, state_reg == F_APPEND,
        "accepted item did not reach the append step")
    `TEAB_ASSERT_IMP(a_append_has_room, clk, rst_n, do_append, fill_reg[ci] < FW'(QUEUE_DEPTH),
        "append into a full fifo")

endmodule

FILE: src/teab_back.sv
// back: finds the lowest head trigger, pops matching heads, drives results
// depends on teab_pkg and the assertion macro header
`include "trigger_aligned_event_builder_assert.svh"
module teab_back import teab_pkg::*; #(
    parameter int CHANNELS = 8,
    parameter int QUEUE_DEPTH = 16,
    localparam int AW = $clog2(CHANNELS * QUEUE_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fe_status_t        status,
    input  logic              overflow,
    input  logic              tok_valid,
    input  check_t            tok,
    output logic              tok_pop,
    output pop_t              pop,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  slot_t             rd_slot,
    output logic              back_busy,
    output logic              out_valid,
    output logic [CHAN_W-1:0] out_channel,
    output logic [TRIG_W-1:0] out_trigger,
    output logic [DATA_W-1:0] out_data,
    output logic              last_fragment,
    output logic              complete,
    output logic              overflow_seen
);

    localparam int CW = $clog2(CHANNELS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(CHANNELS + 1);

    be_state_t         state_reg;
    be_state_t         state_next;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    logic [TRIG_W-1:0] min_reg;
    logic [TRIG_W-1:0] min_next;
    logic [CHANNELS-1:0] pick_reg;
    logic [CHANNELS-1:0] pick_next;
    logic [CHANNELS-1:0] idx_bit;
    logic [NW-1:0]     nact_reg;
    logic [NW-1:0]     nact_next;
    logic [NW-1:0]     npick_reg;
    logic [NW-1:0]     npick_next;
    logic [PW-1:0]     rptr_reg  [CHANNELS];
    logic [PW-1:0]     rptr_next [CHANNELS];
    logic              act_i;
    logic              ne_i;
    logic              last_idx;
    logic              last_pick;
    logic              emit;

    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_channel_reg;
    logic [TRIG_W-1:0] out_trigger_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_complete_reg;
    logic              out_ovf_reg;

    assign act_i     = status.active[idx_reg];
    assign ne_i      = status.nonempty[idx_reg];
    assign last_idx  = (idx_reg == CW'(CHANNELS - 1));
    assign idx_bit   = CHANNELS'(1) << idx_reg;
    assign last_pick = ((pick_reg & ~idx_bit) == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (tok_valid)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (act_i)
                begin
                    // an active channel with nothing stored: no event yet
                    state_next = ne_i ? B_SCAN_WAIT : B_IDLE;
                end
                else if (last_idx)
                begin
                    state_next = (nact_reg == '0) ? B_IDLE : B_EMIT;
                end
            end
            B_SCAN_WAIT:
            begin
                state_next = last_idx ? B_EMIT : B_SCAN;
            end
            B_EMIT:
            begin
                if (pick_reg[idx_reg])
                begin
                    state_next = B_EMIT_WAIT;
                end
            end
            B_EMIT_WAIT:
            begin
                state_next = last_pick ? B_IDLE : B_EMIT;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        tok_pop    = 1'b0;
        rd_en      = 1'b0;
        emit       = 1'b0;
        idx_next   = idx_reg;
        min_next   = min_reg;
        pick_next  = pick_reg;
        nact_next  = nact_reg;
        npick_next = npick_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (tok_valid)
                begin
                    tok_pop    = 1'b1;
                    idx_next   = '0;
                    min_next   = '1;
                    pick_next  = '0;
                    nact_next  = '0;
                    npick_next = '0;
                end
            end
            B_SCAN:
            begin
                if (act_i)
                begin
                    rd_en = ne_i;
                end
                else if (last_idx)
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_SCAN_WAIT:
            begin
                nact_next = nact_reg + 1'b1;
                if (rd_slot.trig < min_reg)
                begin
                    min_next   = rd_slot.trig;
                    pick_next  = idx_bit;
                    npick_next = NW'(1);
                end
                else if (rd_slot.trig == min_reg)
                begin
                    pick_next  = pick_reg | idx_bit;
                    npick_next = npick_reg + 1'b1;
                end
                idx_next = last_idx ? '0 : idx_reg + 1'b1;
            end
            B_EMIT:
            begin
                if (pick_reg[idx_reg])
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            B_EMIT_WAIT:
            begin
                emit      = 1'b1;
                pick_next = pick_reg & ~idx_bit;
                if (!last_pick)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign back_busy = (state_reg != B_IDLE);
    assign pop       = '{valid: emit, channel: CHAN_W'(idx_reg)};
    assign rd_addr   = AW'(int'(idx_reg) * QUEUE_DEPTH + int'(rptr_reg[idx_reg]));

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            rptr_next[i] = rptr_reg[i];
            if (emit && (idx_reg == CW'(i)))
            begin
                rptr_next[i] = (rptr_reg[i] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rptr_reg[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rptr_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= emit;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rptr_reg[i] <= rptr_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        min_reg   <= min_next;
        pick_reg  <= pick_next;
        nact_reg  <= nact_next;
        npick_reg <= npick_next;
        if (emit)
        begin
            out_channel_reg  <= CHAN_W'(idx_reg);
            out_trigger_reg  <= min_reg;
            out_data_reg     <= rd_slot.data;
            out_last_reg     <= last_pick;
            out_complete_reg <= (npick_reg == nact_reg);
            out_ovf_reg      <= overflow;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign out_trigger   = out_trigger_reg;
    assign out_data      = out_data_reg;
    assign last_fragment = out_last_reg;
    assign complete      = out_complete_reg;
    assign overflow_seen = out_ovf_reg;

    `TEAB_ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop.valid, status.nonempty[pop.channel],
        "pop from an empty fifo")
    `TEAB_ASSERT_IMP(a_emit_has_pick, clk, rst_n, state_reg == B_EMIT, pick_reg != '0,
        "emit pass with no channel picked")
    `TEAB_ASSERT_IMP(a_appended_visible, clk, rst_n, tok_pop && tok.appended,
        status.nonempty[tok.channel], "appended fragment not visible to the back")
    `TEAB_ASSERT_IMP(a_last_ends_event, clk, rst_n, out_valid_reg && out_last_reg,
        state_reg == B_IDLE, "back still busy after the last fragment")

endmodule

FILE: src/trigger_aligned_event_builder.sv
// top level of the trigger aligned event builder: front, request queue, back, fragment ram
// depends on teab_pkg, teab_ram, teab_queue, teab_front, teab_back
//
//  channel   direction  handshake            payload
//  input     in         start / busy         channel, trigger_number, fragment_data
//  result    out        out_valid strobe     out_channel, out_trigger, out_data,
//                                            last_fragment, complete, overflow_seen
//  config    in         cfg_we               cfg_data (active mask)
//
// one item at a time: busy stays high from the accept until the back is idle again,
//   as the last result, if any, is registered; the scan ends early with no event
//   when it meets an empty active fifo; the one ram read port serves the head scan
//   and the emit pass one channel per visit
// results are strobed for one cycle and cannot be stalled; fifo storage needs no clearing
module trigger_aligned_event_builder import teab_pkg::*; #(
    parameter int CHANNELS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CHAN_W-1:0] channel,
    input  logic [TRIG_W-1:0] trigger_number,
    input  logic [DATA_W-1:0] fragment_data,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_data,
    output logic              out_valid,
    output logic [CHAN_W-1:0] out_channel,
    output logic [TRIG_W-1:0] out_trigger,
    output logic [DATA_W-1:0] out_data,
    output logic              last_fragment,
    output logic              complete,
    output logic              overflow_seen
);

    localparam int DEPTH = CHANNELS * QUEUE_DEPTH;
    localparam int AW = $clog2(DEPTH);

    logic          accept;
    logic          front_busy;
    logic          back_busy;
    logic          overflow;
    fe_status_t    status;
    pop_t          pop;
    logic          push;
    check_t        push_tok;
    logic          tok_valid;
    check_t        tok;
    logic          tok_pop;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_t         wr_slot;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [SLOT_W-1:0] rd_word;

    assign busy   = front_busy | tok_valid | back_busy;
    assign accept = start & ~busy;

    teab_front #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .channel        (channel),
        .trigger_number (trigger_number),
        .fragment_data  (fragment_data),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .pop            (pop),
        .status         (status),
        .push           (push),
        .push_tok       (push_tok),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_slot        (wr_slot),
        .front_busy     (front_busy),
        .overflow       (overflow)
    );

    teab_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .pop       (tok_pop),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    teab_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_slot),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_word)
    );

    teab_back #(
        .CHANNELS    (CHANNELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .status        (status),
        .overflow      (overflow),
        .tok_valid     (tok_valid),
        .tok           (tok),
        .tok_pop       (tok_pop),
        .pop           (pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_slot       (slot_t'(rd_word)),
        .back_busy     (back_busy),
        .out_valid     (out_valid),
        .out_channel   (out_channel),
        .out_trigger   (out_trigger),
        .out_data      (out_data),
        .last_fragment (last_fragment),
        .complete      (complete),
        .overflow_seen (overflow_seen)
    );

endmodule
